// File: rtl/ffud_pkg.sv
package ffud_pkg;

    localparam int KEY_BYTES = 8;
    localparam int KPOS_W    = 3;
    localparam int KLEN_W    = 4;
    localparam int NSLOT     = 4;
    localparam int SLOT_W    = 2;
    localparam int CNT_W     = 3;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;
    localparam int QCNT_W    = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        PH_KEY,
        PH_VALUE,
        PH_SKIP,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [7:0] data;
        logic       is_end;
        logic       found;
    } t_res;

    typedef struct packed {
        logic [CNT_W-1:0]     cnt;
        t_res [NSLOT-1:0]     slots;
    } t_cmd;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        if (c <= 8'h39) begin
            return c[3:0];
        end
        return c[3:0] + 4'd9;
    endfunction

endpackage

// File: rtl/form_field_url_decoder.sv
// Form field extractor with percent decoding.
// Input stream: one body byte per word on s_axis_tdata, s_axis_tlast on the
// final byte. Output stream: one result per word; tuser[0] = byte_valid with
// the decoded byte on tdata, tlast = end marker with tuser[1] = found.
// Config channel: index 0 writes the key bytes (first char in bits 7:0),
// index 1 writes the key length (bits 3:0). Always ready; write only idle.
// The parser takes one byte per cycle and turns it into a bundle of 0 to 4
// results, held in a 4-entry queue; the output side drains one result per
// cycle. Each result passes through the queue, r_cmd and the output register.
// Sustained rate is one byte per cycle while each byte gives at most one
// result; escape flushes and end markers add more results to a bundle.
// Reset clears the key registers to zero, the parse state and the queue.
// When the receiver stalls the output word holds, the queue fills, and
// s_axis_tready drops once the queue is full.
module form_field_url_decoder import ffud_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // in_byte
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // value_byte
    output logic [1:0]           m_axis_tuser,   // byte_valid, found
    output logic                 m_axis_tlast,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data
);

    logic accept, push, q_full, q_valid, q_pop;
    t_cmd f_cmd, q_cmd;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && !q_full;

    ffud_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_byte      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .o_push      (push),
        .o_cmd       (f_cmd)
    );

    ffud_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    ffud_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_tdata   (m_axis_tdata),
        .o_tuser   (m_axis_tuser),
        .o_tlast   (m_axis_tlast)
    );

endmodule

// File: rtl/ffud_front.sv
module ffud_front import ffud_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    input  logic                 i_accept,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    output logic                 o_push,
    output t_cmd                 o_cmd
);

    logic [KEY_BYTES-1:0][7:0] r_key;
    logic [KLEN_W-1:0]         r_klen;
    t_phase                    r_phase, n_phase, s_phase;
    logic [KLEN_W-1:0]         r_pos, n_pos, s_pos;
    logic                      r_mis, n_mis, s_mis;
    logic [1:0]                r_hcnt, n_hcnt, s_hcnt;
    logic [7:0]                r_hdig, n_hdig, s_hdig;

    logic [KLEN_W-1:0] klen;
    logic              hex_b, is_amp, is_eq;

    assign klen   = (r_klen > KLEN_W'(KEY_BYTES)) ? KLEN_W'(KEY_BYTES) : r_klen;
    assign hex_b  = is_hex(i_byte);
    assign is_amp = (i_byte == CH_AMP);
    assign is_eq  = (i_byte == CH_EQ);

    // parse state after this byte, then the end-of-body clear
    always_comb begin : next_state
        s_phase = r_phase;
        s_pos   = r_pos;
        s_mis   = r_mis;
        s_hcnt  = r_hcnt;
        s_hdig  = r_hdig;
        case (r_phase)
            PH_KEY: begin
                if (is_amp) begin
                    s_pos = '0;
                    s_mis = 1'b0;
                end else if (is_eq) begin
                    if (!r_mis && r_pos == klen) begin
                        s_phase = PH_VALUE;
                        s_hcnt  = 2'd0;
                    end else begin
                        s_phase = PH_SKIP;
                    end
                end else if (!r_mis) begin
                    if (r_pos < klen && r_key[r_pos[KPOS_W-1:0]] == i_byte) begin
                        s_pos = r_pos + 1'b1;
                    end else begin
                        s_mis = 1'b1;
                    end
                end
            end
            PH_VALUE: begin
                if (r_hcnt == 2'd1 && hex_b) begin
                    s_hdig = i_byte;
                    s_hcnt = 2'd2;
                end else if (r_hcnt == 2'd2 && hex_b) begin
                    s_hcnt = 2'd0;
                end else begin
                    s_hcnt = 2'd0;
                    if (i_byte == CH_PCT) begin
                        s_hcnt = 2'd1;
                    end else if (is_amp) begin
                        s_phase = PH_DONE;
                    end
                end
            end
            PH_SKIP: begin
                if (is_amp) begin
                    s_phase = PH_KEY;
                    s_pos   = '0;
                    s_mis   = 1'b0;
                end
            end
            default: begin
            end
        endcase

        n_phase = s_phase;
        n_pos   = s_pos;
        n_mis   = s_mis;
        n_hcnt  = s_hcnt;
        n_hdig  = s_hdig;
        if (i_last) begin
            n_phase = PH_KEY;
            n_pos   = '0;
            n_mis   = 1'b0;
            n_hcnt  = 2'd0;
        end
    end

    // results caused by this byte
    always_comb begin : outputs
        logic [CNT_W-1:0] k;
        k     = '0;
        o_cmd = '0;
        if (r_phase == PH_VALUE) begin
            if (r_hcnt == 2'd1 && hex_b) begin
                k = k;
            end else if (r_hcnt == 2'd2 && hex_b) begin
                o_cmd.slots[k[SLOT_W-1:0]] = '{data: {hex_val(r_hdig), hex_val(i_byte)},
                                               is_end: 1'b0, found: 1'b0};
                k = k + 1'b1;
            end else begin
                if (r_hcnt != 2'd0) begin
                    o_cmd.slots[k[SLOT_W-1:0]] = '{data: CH_PCT, is_end: 1'b0, found: 1'b0};
                    k = k + 1'b1;
                end
                if (r_hcnt == 2'd2) begin
                    o_cmd.slots[k[SLOT_W-1:0]] = '{data: r_hdig, is_end: 1'b0, found: 1'b0};
                    k = k + 1'b1;
                end
                if (i_byte == CH_PCT) begin
                    k = k;
                end else if (i_byte == CH_PLUS) begin
                    o_cmd.slots[k[SLOT_W-1:0]] = '{data: CH_SPACE, is_end: 1'b0, found: 1'b0};
                    k = k + 1'b1;
                end else if (is_amp) begin
                    o_cmd.slots[k[SLOT_W-1:0]] = '{data: 8'h00, is_end: 1'b1, found: 1'b1};
                    k = k + 1'b1;
                end else begin
                    o_cmd.slots[k[SLOT_W-1:0]] = '{data: i_byte, is_end: 1'b0, found: 1'b0};
                    k = k + 1'b1;
                end
            end
        end
        if (i_last) begin
            if (s_phase == PH_VALUE) begin
                if (s_hcnt != 2'd0) begin
                    o_cmd.slots[k[SLOT_W-1:0]] = '{data: CH_PCT, is_end: 1'b0, found: 1'b0};
                    k = k + 1'b1;
                end
                if (s_hcnt == 2'd2) begin
                    o_cmd.slots[k[SLOT_W-1:0]] = '{data: s_hdig, is_end: 1'b0, found: 1'b0};
                    k = k + 1'b1;
                end
                o_cmd.slots[k[SLOT_W-1:0]] = '{data: 8'h00, is_end: 1'b1, found: 1'b1};
                k = k + 1'b1;
            end else if (s_phase != PH_DONE) begin
                o_cmd.slots[k[SLOT_W-1:0]] = '{data: 8'h00, is_end: 1'b1, found: 1'b0};
                k = k + 1'b1;
            end
        end
        o_cmd.cnt = k;
    end

    assign o_push = i_accept && (o_cmd.cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= '0;
            r_klen  <= '0;
            r_phase <= PH_KEY;
            r_pos   <= '0;
            r_mis   <= 1'b0;
            r_hcnt  <= 2'd0;
            r_hdig  <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_KEY_BYTES:  r_key  <= i_cfg_data;
                    CFG_KEY_LENGTH: r_klen <= i_cfg_data[KLEN_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_accept) begin
                r_phase <= n_phase;
                r_pos   <= n_pos;
                r_mis   <= n_mis;
                r_hcnt  <= n_hcnt;
                r_hdig  <= n_hdig;
            end
        end
    end

endmodule

// File: rtl/ffud_queue.sv
module ffud_queue import ffud_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && do_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: rtl/ffud_back.sv
module ffud_back import ffud_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_cmd       i_q_cmd,
    output logic       o_q_pop,
    output logic       o_tvalid,
    input  logic       i_tready,
    output logic [7:0] o_tdata,
    output logic [1:0] o_tuser,
    output logic       o_tlast
);

    t_cmd              r_cmd;
    logic [SLOT_W-1:0] r_idx;
    logic              r_have;
    logic              r_ovalid;
    logic [7:0]        r_odata;
    logic [1:0]        r_ouser;
    logic              r_olast;

    t_res cur;
    logic out_load, take, fin;

    assign cur      = r_cmd.slots[r_idx];
    assign out_load = !r_ovalid || i_tready;
    assign take     = out_load && r_have;
    assign fin      = (r_idx == r_cmd.cnt[SLOT_W-1:0] - SLOT_W'(1));
    assign o_q_pop  = !r_have || (take && fin);

    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_q_valid) begin
            r_cmd <= i_q_cmd;
        end
        if (take) begin
            r_odata <= cur.data;
            r_ouser <= {cur.found, !cur.is_end};
            r_olast <= cur.is_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_have   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (out_load) begin
                r_ovalid <= r_have;
            end
            if (o_q_pop) begin
                r_have <= i_q_valid;
                r_idx  <= '0;
            end else if (take) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    assign o_tvalid = r_ovalid;
    assign o_tdata  = r_odata;
    assign o_tuser  = r_ouser;
    assign o_tlast  = r_olast;

endmodule

// File: sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ffud_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RST_CYCLES  = 11;
    localparam int QUIET_MAX   = 2000;
    localparam int SETTLE      = 8;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 8;
    localparam int FILL_BYTES  = 12;
    localparam string ALNUM    = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
    localparam string HEXCH    = "0123456789abcdefABCDEF";

    typedef struct packed {
        logic [7:0] value;
        logic       has_data;
        logic       is_end;
        logic       found;
    } t_word;

    typedef struct packed {
        logic       new_key;
        logic [7:0] in_byte;
        logic       last;
        logic       typed;
        logic [1:0] nwant;
        t_word      w0;
        t_word      w1;
    } t_body_byte;

    localparam t_word NO_W     = '0;
    localparam t_word END_MISS = '{8'h00, 1'b0, 1'b1, 1'b0};
    localparam t_word END_HIT  = '{8'h00, 1'b0, 1'b1, 1'b1};
    localparam t_word SPACE_W  = '{CH_SPACE, 1'b1, 1'b0, 1'b0};
    localparam t_word ZERO_W   = '{8'h00, 1'b1, 1'b0, 1'b0};

    localparam int DIR_N = 30;
    // typed rows carry their answer; the rest go through the decoder model
    localparam t_body_byte DIR_ROWS [DIR_N] = '{
        '{1'b0, "a",     1'b1, 1'b1, 2'd1, END_MISS, NO_W},
        '{1'b0, CH_EQ,   1'b0, 1'b0, 2'd0, NO_W, NO_W},
        '{1'b0, CH_PLUS, 1'b1, 1'b1, 2'd2, SPACE_W, END_HIT},
        '{1'b1, "k",     1'b0, 1'b0, 2'd0, NO_W, NO_W},
        '{1'b0, "e",     1'b0, 1'b0, 2'd0, NO_W, NO_W},
        '{1'b0, "y",     1'b0, 1'b0, 2'd0, NO_W, NO_W},
        '{1'b0, CH_EQ,   1'b0, 1'b0, 2'd0, NO_W, NO_W},
        '{1'b0, CH_PCT,  1'b0, 1'b0, 2'd0, NO_W, NO_W},
        '{1'b0, "4",     1'b0, 1'b0, 2'd0, NO_W, NO_W},
        '{1'b0, "a",     1'b0, 1'b0, 2'd0, NO_W, NO_W},
        '{1'b0, CH_PLUS, 1'b0, 1'b1, 2'd1, SPACE_W, NO_W},
        '{1'b0, CH_PCT,  1'b0, 1'b0, 2'd0, NO_W, NO_W},
        '{1'b0, "z",     1'b0, 1'b0, 2'd0, NO_W, NO_W},
        '{1'b0, CH_PCT,  1'b0, 1'b0, 2'd0, NO_W, NO_W},
        '{1'b0, "4",     1'b0, 1'b0, 2'd0, NO_W, NO_W},
        '{1'b0, "G",     1'b0, 1'b0, 2'd0, NO_W, NO_W},
        '{1'b0, CH_PCT,  1'b0, 1'b0, 2'd0, NO_W, NO_W},
        '{1'b0, "7",     1'b0, 1'b0, 2'd0, NO_W, NO_W},
        '{1'b0, CH_AMP,  1'b0, 1'b0, 2'd0, NO_W, NO_W},
        '{1'b0, "q",     1'b1, 1'b1, 2'd0, NO_W, NO_W},
        '{1'b1, 8'hFF,   1'b0, 1'b0, 2'd0, NO_W, NO_W},
        '{1'b0, 8'hFF,   1'b0, 1'b0, 2'd0, NO_W, NO_W},
        '{1'b0, 8'hFF,   1'b0, 1'b0, 2'd0, NO_W, NO_W},
        '{1'b0, 8'hFF,   1'b0, 1'b0, 2'd0, NO_W, NO_W},
        '{1'b0, 8'hFF,   1'b0, 1'b0, 2'd0, NO_W, NO_W},
        '{1'b0, 8'hFF,   1'b0, 1'b0, 2'd0, NO_W, NO_W},
        '{1'b0, 8'hFF,   1'b0, 1'b0, 2'd0, NO_W, NO_W},
        '{1'b0, 8'hFF,   1'b0, 1'b0, 2'd0, NO_W, NO_W},
        '{1'b0, CH_EQ,   1'b0, 1'b0, 2'd0, NO_W, NO_W},
        '{1'b0, 8'h00,   1'b1, 1'b1, 2'd2, ZERO_W, END_HIT}
    };
    localparam logic [63:0] DIR_KEYS [2] = '{64'h0000_0000_0079_656B, '1};
    localparam logic [3:0]  DIR_LENS [2] = '{4'd3, 4'd15};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = 8'h00;
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;
    logic [1:0]           m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_KEY_BYTES;
    logic [63:0]          i_cfg_data = 64'd0;

    form_field_url_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // decoder model state
    logic [63:0] key_chars = 64'd0;
    logic [3:0]  key_len   = 4'd0;
    t_phase      ph        = PH_KEY;
    logic [3:0]  kpos      = 4'd0;
    logic        kmis      = 1'b0;
    logic [1:0]  hcnt      = 2'd0;
    logic [15:0] hbytes    = 16'd0;

    t_word      bundle_q[$];
    t_word      pending[$];
    t_body_byte in_q[$];
    t_body_byte cur_row;

    int fail_count   = 0;
    int live_items   = 0;
    int in_accepted  = 0;
    int idle_pct     = 23;
    int hold_left    = 0;
    bit squeeze_req  = 1'b0;
    bit squeeze_done = 1'b0;
    int quiet        = 0;

    task automatic report(input string msg);
        if (fail_count < 40) begin
            $display("mismatch @%0t: %s", $realtime, msg);
        end
        fail_count++;
    endtask

    function automatic bit hex_digit(input logic [7:0] c, output logic [3:0] v);
        v = 4'd0;
        if (c >= "0" && c <= "9") begin
            v = 4'(c - "0");
            return 1'b1;
        end
        if (c >= "a" && c <= "f") begin
            v = 4'(c - "a" + 8'd10);
            return 1'b1;
        end
        if (c >= "A" && c <= "F") begin
            v = 4'(c - "A" + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void emit(input logic [7:0] v, input logic d, input logic e,
                                 input logic f);
        t_word w;
        w = '{v, d, e, f};
        bundle_q.push_back(w);
    endfunction

    function automatic void flush_escape();
        if (hcnt >= 2'd1) emit(hbytes[7:0], 1'b1, 1'b0, 1'b0);
        if (hcnt >= 2'd2) emit(hbytes[15:8], 1'b1, 1'b0, 1'b0);
        hcnt   = 2'd0;
        hbytes = 16'd0;
    endfunction

    function automatic void decode_value(input logic [7:0] b);
        logic [3:0] hi, lo;
        if (hcnt == 2'd1) begin
            if (hex_digit(b, lo)) begin
                hbytes[15:8] = b;
                hcnt = 2'd2;
                return;
            end
            flush_escape();
        end else if (hcnt == 2'd2) begin
            if (hex_digit(b, lo)) begin
                void'(hex_digit(hbytes[15:8], hi));
                emit({hi, lo}, 1'b1, 1'b0, 1'b0);
                hcnt   = 2'd0;
                hbytes = 16'd0;
                return;
            end
            flush_escape();
        end
        if (b == CH_PCT) begin
            hbytes = {8'h00, CH_PCT};
            hcnt   = 2'd1;
        end else if (b == CH_PLUS) begin
            emit(CH_SPACE, 1'b1, 1'b0, 1'b0);
        end else if (b == CH_AMP) begin
            emit(8'h00, 1'b0, 1'b1, 1'b1);
            ph = PH_DONE;
        end else begin
            emit(b, 1'b1, 1'b0, 1'b0);
        end
    endfunction

    // returns 1 when the byte comes in the key or value phase, or ends the body
    function automatic bit decode_byte(input logic [7:0] b, input logic last);
        logic [3:0] klen;
        bit live;
        klen = (key_len > 4'd8) ? 4'd8 : key_len;
        live = last || ph == PH_KEY || ph == PH_VALUE;
        case (ph)
            PH_KEY: begin
                if (b == CH_AMP) begin
                    kpos = 4'd0;
                    kmis = 1'b0;
                end else if (b == CH_EQ) begin
                    if (!kmis && kpos == klen) begin
                        ph     = PH_VALUE;
                        hcnt   = 2'd0;
                        hbytes = 16'd0;
                    end else begin
                        ph = PH_SKIP;
                    end
                end else if (!kmis) begin
                    if (kpos < klen && key_chars[8*kpos +: 8] == b) kpos = kpos + 4'd1;
                    else kmis = 1'b1;
                end
            end
            PH_VALUE: decode_value(b);
            PH_SKIP: begin
                if (b == CH_AMP) begin
                    ph   = PH_KEY;
                    kpos = 4'd0;
                    kmis = 1'b0;
                end
            end
            default: ;
        endcase
        if (last) begin
            if (ph == PH_VALUE) begin
                flush_escape();
                emit(8'h00, 1'b0, 1'b1, 1'b1);
            end else if (ph != PH_DONE) begin
                emit(8'h00, 1'b0, 1'b1, 1'b0);
            end
            ph     = PH_KEY;
            kpos   = 4'd0;
            kmis   = 1'b0;
            hcnt   = 2'd0;
            hbytes = 16'd0;
        end
        return live;
    endfunction

    // input side: present words, model each accepted byte
    always @(posedge i_clk) begin : feed
        bit live;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                bundle_q.delete();
                live = decode_byte(s_axis_tdata, s_axis_tlast);
                if (live) live_items++;
                in_accepted++;
                if (cur_row.typed) begin
                    if (cur_row.nwant > 2'd0) pending.push_back(cur_row.w0);
                    if (cur_row.nwant > 2'd1) pending.push_back(cur_row.w1);
                end else begin
                    foreach (bundle_q[k]) pending.push_back(bundle_q[k]);
                end
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (in_q.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
                    cur_row = in_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= cur_row.in_byte;
                    s_axis_tlast  <= cur_row.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side: check each word, stall at random, one long hold-off
    always @(posedge i_clk) begin : drain
        t_word got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]};
                if (pending.size() == 0) begin
                    report($sformatf("unexpected word data=%h valid=%b end=%b found=%b",
                                     got.value, got.has_data, got.is_end, got.found));
                end else begin
                    want = pending.pop_front();
                    if (got != want) begin
                        report($sformatf({"data=%h/%h valid=%b/%b end=%b/%b found=%b/%b",
                                          " (got/want)"},
                                         got.value, want.value, got.has_data, want.has_data,
                                         got.is_end, want.is_end, got.found, want.found));
                    end
                end
            end
            if (!squeeze_done && squeeze_req) begin
                hold_left    = 100;
                squeeze_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99, 0) >= idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
        end
        if (quiet >= QUIET_MAX) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_KEY_BYTES) key_chars = data;
        else key_len = data[3:0];
    endtask

    task automatic settle();
        while (in_q.size() != 0 || s_axis_tvalid || pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick(input string s);
        return s[$urandom_range(s.len() - 1, 0)];
    endfunction

    // matching key with a long plain value: one result per value byte, plus the end marker
    task automatic add_value_body();
        t_body_byte r;
        int kl;
        kl = (key_len > 4'd8) ? 8 : int'(key_len);
        r = '0;
        for (int i = 0; i < kl; i++) begin
            r.in_byte = key_chars[8*i +: 8];
            in_q.push_back(r);
        end
        r.in_byte = CH_EQ;
        in_q.push_back(r);
        for (int i = 0; i < FILL_BYTES; i++) begin
            r.in_byte = pick(ALNUM);
            r.last    = (i == FILL_BYTES - 1);
            in_q.push_back(r);
        end
    endtask

    task automatic add_body();
        logic [7:0] body[$];
        t_body_byte r;
        int npairs, n, kl;
        kl = (key_len > 4'd8) ? 8 : int'(key_len);
        if ($urandom_range(9, 0) == 0) begin
            n = $urandom_range(8, 1);
            repeat (n) body.push_back(8'($urandom_range(255, 0)));
        end else begin
            npairs = $urandom_range(4, 1);
            for (int p = 0; p < npairs; p++) begin
                if (p > 0 || $urandom_range(9, 0) == 0) body.push_back(CH_AMP);
                n = $urandom_range(99, 0);
                if (n < 50) begin
                    for (int i = 0; i < kl; i++) body.push_back(key_chars[8*i +: 8]);
                end else if (n < 65) begin
                    for (int i = 0; i < kl - 1; i++) body.push_back(key_chars[8*i +: 8]);
                    if ($urandom_range(1, 0)) begin
                        if (kl > 0) body.push_back(key_chars[8*(kl-1) +: 8]);
                        body.push_back(pick(ALNUM));
                    end
                end else if (n < 80) begin
                    repeat ($urandom_range(4, 1)) body.push_back(pick(ALNUM));
                end else begin
                    repeat ($urandom_range(3, 0)) body.push_back(8'($urandom_range(255, 0)));
                end
                if ($urandom_range(99, 0) < 88) begin
                    body.push_back(CH_EQ);
                    repeat ($urandom_range(5, 0)) begin
                        case ($urandom_range(7, 0))
                            0: begin
                                body.push_back(CH_PCT);
                                body.push_back(pick(HEXCH));
                                body.push_back(pick(HEXCH));
                            end
                            1: body.push_back(CH_PLUS);
                            2: begin
                                body.push_back(CH_PCT);
                                body.push_back(pick(ALNUM));
                            end
                            3: begin
                                body.push_back(CH_PCT);
                                body.push_back(pick(HEXCH));
                                body.push_back(8'($urandom_range(255, 0)));
                            end
                            4, 5: body.push_back(pick(ALNUM));
                            6: body.push_back(8'($urandom_range(255, 0)));
                            default: begin
                                body.push_back(CH_PCT);
                                if ($urandom_range(1, 0)) body.push_back(pick(HEXCH));
                            end
                        endcase
                    end
                end else begin
                    repeat ($urandom_range(3, 1)) body.push_back(pick(ALNUM));
                end
            end
        end
        if (body.size() == 0) body.push_back(pick(ALNUM));
        foreach (body[i]) begin
            r = '0;
            r.in_byte = body[i];
            r.last    = (i == body.size() - 1);
            in_q.push_back(r);
        end
    endtask

    initial begin : stimulus
        int sec, target, kl;
        logic [63:0] key, lenw;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sec = 0;
        for (int k = 0; k < DIR_N; k++) begin
            if (DIR_ROWS[k].new_key) begin
                settle();
                write_reg(CFG_KEY_BYTES, DIR_KEYS[sec]);
                write_reg(CFG_KEY_LENGTH, {60'd0, DIR_LENS[sec]});
                sec++;
            end
            in_q.push_back(DIR_ROWS[k]);
        end

        for (int p = 0; p < PHASES; p++) begin
            settle();
            if (p == 0) kl = 8;
            else if (p == 5) kl = 0;
            else if (p == 6) kl = $urandom_range(15, 9);
            else kl = $urandom_range(7, 1);
            key = {$urandom, $urandom};
            if (p != 7) begin
                for (int i = 0; i < 8; i++) key[8*i +: 8] = pick(ALNUM);
            end
            lenw = {$urandom, $urandom};
            lenw[3:0] = 4'(kl);
            if ($urandom_range(1, 0)) begin
                write_reg(CFG_KEY_BYTES, key);
                write_reg(CFG_KEY_LENGTH, lenw);
            end else begin
                write_reg(CFG_KEY_LENGTH, lenw);
                write_reg(CFG_KEY_BYTES, key);
            end
            idle_pct = (p == 3) ? 0 : 23;
            target = in_accepted + ((p == 3) ? 4 * PHASE_ITEMS : PHASE_ITEMS);
            if (p == 4) begin
                squeeze_req = 1'b1;
                add_value_body();
                while (in_q.size() != 0) @(posedge i_clk);
            end
            while (in_accepted < target) begin
                add_body();
                while (in_q.size() != 0) @(posedge i_clk);
            end
        end

        settle();
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/ffud_pkg.sv
rtl/ffud_front.sv
rtl/ffud_queue.sv
rtl/ffud_back.sv
rtl/form_field_url_decoder.sv
sim/tb_top.sv
